// ===== rtl/imusc_pkg.sv =====
package imusc_pkg;

  localparam int unsigned RawW    = 16;
  localparam int unsigned ScaleW  = 32;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned OffW    = 21;
  localparam int unsigned ResW    = 32;
  localparam int unsigned IdxW    = 3;
  localparam int unsigned CfgDataW = 63;
  localparam int unsigned Axes    = 3;

  // Widths of the intermediate values.
  localparam int unsigned ProdW   = RawW + ScaleW;        // raw times scale
  localparam int unsigned ScaledW = ProdW - 8;            // Q.16 scaled acceleration
  localparam int unsigned WProdW  = CoefW + ScaledW;      // weight times scaled
  localparam int unsigned SumW    = WProdW + 2;           // three terms and an offset
  localparam int unsigned SatInW  = 48;

  typedef enum logic [IdxW-1:0] {
    REG_ACCEL_SCALE   = 3'd0,
    REG_GYRO_SCALE    = 3'd1,
    REG_COEF_FOR_X    = 3'd2,
    REG_COEF_FOR_Y    = 3'd3,
    REG_COEF_FOR_Z    = 3'd4,
    REG_ACCEL_OFFSETS = 3'd5,
    REG_GYRO_OFFSETS  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic signed [RawW-1:0] acc_raw_x;
    logic signed [RawW-1:0] acc_raw_y;
    logic signed [RawW-1:0] acc_raw_z;
    logic signed [RawW-1:0] rot_raw_x;
    logic signed [RawW-1:0] rot_raw_y;
    logic signed [RawW-1:0] rot_raw_z;
  } in_item_t;

  typedef struct packed {
    logic signed [ResW-1:0] acc_out_x;
    logic signed [ResW-1:0] acc_out_y;
    logic signed [ResW-1:0] acc_out_z;
    logic signed [ResW-1:0] rot_out_x;
    logic signed [ResW-1:0] rot_out_y;
    logic signed [ResW-1:0] rot_out_z;
  } out_item_t;

  typedef struct packed {
    logic [ScaleW-1:0]                 accel_scale;
    logic [ScaleW-1:0]                 gyro_scale;
    logic [Axes-1:0][Axes*CoefW-1:0]   coef;
    logic [CfgDataW-1:0]               accel_off;
    logic [CfgDataW-1:0]               gyro_off;
  } cfg_t;

  // Scaled acceleration and finished rates handed from the scaling stages to the matrix.
  typedef struct packed {
    logic [Axes-1:0][ScaledW-1:0] acc_sc;
    logic [Axes-1:0][ResW-1:0]    rot;
  } scaled_t;

  localparam logic [ScaleW-1:0] ScaleOne = 32'h0100_0000;
  localparam logic [CoefW-1:0]  CoefOne  = 16'h1000;

  localparam cfg_t CfgReset = '{
    accel_scale: ScaleOne,
    gyro_scale:  ScaleOne,
    coef:        {{CoefOne, 16'h0000, 16'h0000},
                  {16'h0000, CoefOne, 16'h0000},
                  {16'h0000, 16'h0000, CoefOne}},
    accel_off:   '0,
    gyro_off:    '0
  };

  // Clamp a wide signed value into the signed 32-bit result range.
  function automatic logic [ResW-1:0] sat_res(input logic [SatInW-1:0] v);
    logic [ResW-1:0] r;
    if (v[SatInW-1:ResW-1] == '0 || v[SatInW-1:ResW-1] == '1) begin
      r = v[ResW-1:0];
    end else if (v[SatInW-1]) begin
      r = {1'b1, {(ResW-1){1'b0}}};
    end else begin
      r = {1'b0, {(ResW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== rtl/imusc_if.sv =====
interface imusc_in_if;
  logic                valid;
  logic                ready;
  imusc_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface imusc_out_if;
  logic                 valid;
  logic                 ready;
  imusc_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/imusc_cfg.sv =====
module imusc_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [imusc_pkg::IdxW-1:0]         cfg_idx_i,
  input  logic [imusc_pkg::CfgDataW-1:0]     cfg_data_i,
  output imusc_pkg::cfg_t                    cfg_o
);
  import imusc_pkg::*;

  cfg_t cfg_q;

  // Writes beyond the register list fall into the default arm and are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_ACCEL_SCALE:   cfg_q.accel_scale <= cfg_data_i[ScaleW-1:0];
        REG_GYRO_SCALE:    cfg_q.gyro_scale  <= cfg_data_i[ScaleW-1:0];
        REG_COEF_FOR_X:    cfg_q.coef[0]     <= cfg_data_i[Axes*CoefW-1:0];
        REG_COEF_FOR_Y:    cfg_q.coef[1]     <= cfg_data_i[Axes*CoefW-1:0];
        REG_COEF_FOR_Z:    cfg_q.coef[2]     <= cfg_data_i[Axes*CoefW-1:0];
        REG_ACCEL_OFFSETS: cfg_q.accel_off   <= cfg_data_i;
        REG_GYRO_OFFSETS:  cfg_q.gyro_off    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/imusc_scale.sv =====
module imusc_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  imusc_pkg::cfg_t      cfg_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  imusc_pkg::in_item_t  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output imusc_pkg::scaled_t   out_data_o
);
  import imusc_pkg::*;

  logic                     v1_q, v2_q;
  logic                     en1, en2;
  logic signed [ProdW-1:0]  acc_p_d [Axes];
  logic signed [ProdW-1:0]  rot_p_d [Axes];
  logic signed [ProdW-1:0]  acc_p_q [Axes];
  logic signed [ProdW-1:0]  rot_p_q [Axes];
  logic signed [RawW-1:0]   acc_raw [Axes];
  logic signed [RawW-1:0]   rot_raw [Axes];
  scaled_t                  s2_d, s2_q;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  assign acc_raw[0] = in_data_i.acc_raw_x;
  assign acc_raw[1] = in_data_i.acc_raw_y;
  assign acc_raw[2] = in_data_i.acc_raw_z;
  assign rot_raw[0] = in_data_i.rot_raw_x;
  assign rot_raw[1] = in_data_i.rot_raw_y;
  assign rot_raw[2] = in_data_i.rot_raw_z;

  // First stage: six multiplications of a raw count by its unsigned scale.
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      acc_p_d[a] = acc_raw[a] * $signed({1'b0, cfg_i.accel_scale});
      rot_p_d[a] = rot_raw[a] * $signed({1'b0, cfg_i.gyro_scale});
    end
  end

  // Second stage: round the acceleration to Q.16, finish the rates completely.
  always_comb begin
    logic [ProdW-1:0]   rnd;
    logic [ProdW:0]     gv;
    logic [OffW-1:0]    off;
    s2_d = '0;
    for (int a = 0; a < Axes; a++) begin
      rnd = acc_p_q[a] + ProdW'(128);
      s2_d.acc_sc[a] = rnd[ProdW-1:8];
      off = cfg_i.gyro_off[OffW*a +: OffW];
      gv  = {acc_p_q[a][ProdW-1] & 1'b0 | rot_p_q[a][ProdW-1], rot_p_q[a]}
          - {{(ProdW-OffW-8+1){off[OffW-1]}}, off, 8'd0}
          + (ProdW+1)'(128);
      s2_d.rot[a] = sat_res({{(SatInW-(ProdW+1-8)){gv[ProdW]}}, gv[ProdW:8]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) begin
        v1_q <= in_valid_i;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1 && in_valid_i) begin
      acc_p_q <= acc_p_d;
      rot_p_q <= rot_p_d;
    end
    if (en2 && v1_q) begin
      s2_q <= s2_d;
    end
  end

  assign out_valid_o = v2_q;
  assign out_data_o  = s2_q;

endmodule

// ===== rtl/imusc_matrix.sv =====
module imusc_matrix (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  imusc_pkg::cfg_t       cfg_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  imusc_pkg::scaled_t    in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output imusc_pkg::out_item_t  out_data_o
);
  import imusc_pkg::*;

  logic                      v3_q, v4_q;
  logic                      en3, en4;
  logic signed [WProdW-1:0]  m_d [Axes][Axes];
  logic signed [WProdW-1:0]  m_q [Axes][Axes];
  logic [Axes-1:0][ResW-1:0] rot3_q;
  logic [Axes-1:0][ResW-1:0] res_d;
  out_item_t                 out_q;

  assign en4        = !v4_q || out_ready_i;
  assign en3        = !v3_q || en4;
  assign in_ready_o = en3;

  // Third stage: the nine weight products of the calibration matrix.
  always_comb begin
    for (int a = 0; a < Axes; a++) begin
      for (int i = 0; i < Axes; i++) begin
        m_d[a][i] = $signed(cfg_i.coef[a][CoefW*i +: CoefW])
                  * $signed(in_data_i.acc_sc[i]);
      end
    end
  end

  // Fourth stage: row sum plus offset, round to Q.16 and saturate.
  always_comb begin
    logic signed [SumW-1:0] sum;
    logic signed [SumW-1:0] ot;
    logic        [OffW-1:0] off;
    for (int a = 0; a < Axes; a++) begin
      off = cfg_i.accel_off[OffW*a +: OffW];
      ot  = {{(SumW-OffW-12){off[OffW-1]}}, off, 12'd0};
      sum = SumW'(m_q[a][0]) + SumW'(m_q[a][1]) + SumW'(m_q[a][2]) + ot
          + SumW'(2048);
      res_d[a] = sat_res({{(SatInW-(SumW-12)){sum[SumW-1]}}, sum[SumW-1:12]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (en3) begin
        v3_q <= in_valid_i;
      end
      if (en4) begin
        v4_q <= v3_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3 && in_valid_i) begin
      m_q    <= m_d;
      rot3_q <= in_data_i.rot;
    end
    if (en4 && v3_q) begin
      out_q.acc_out_x <= res_d[0];
      out_q.acc_out_y <= res_d[1];
      out_q.acc_out_z <= res_d[2];
      out_q.rot_out_x <= rot3_q[0];
      out_q.rot_out_y <= rot3_q[1];
      out_q.rot_out_z <= rot3_q[2];
    end
  end

  assign out_valid_o = v4_q;
  assign out_data_o  = out_q;

endmodule

// ===== rtl/imu_sample_scale_and_calibrate.sv =====
// Throughput: one request per cycle while the output is not stalled; the four stages
// advance independently, so a bubble closes up and a stalled output holds the pipe
// without losing or repeating a request.
// Reset (rst_ni, asynchronous, active low) empties the pipe and returns every
// calibration register to identity: unit scales, unit matrix, zero offsets.
module imu_sample_scale_and_calibrate (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  imusc_in_if.sink                       in_i,
  imusc_out_if.source                    out_o,
  input  logic                           cfg_we_i,
  input  logic [imusc_pkg::IdxW-1:0]     cfg_idx_i,
  input  logic [imusc_pkg::CfgDataW-1:0] cfg_data_i
);
  import imusc_pkg::*;

  cfg_t    cfg;
  logic    s2_valid;
  logic    s2_ready;
  scaled_t s2_data;

  // The calibration register file. Software must write it only while the pipe is empty;
  // the block does not enforce this. Every stage reads the live register values directly.
  imusc_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  // Stages one and two: raw counts times the inverse scales, then rounding to Q.16.
  // The gyroscope path is finished here, offset and saturation included.
  imusc_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .in_data_i   (in_i.data),
    .out_valid_o (s2_valid),
    .out_ready_i (s2_ready),
    .out_data_o  (s2_data)
  );

  // Stages three and four: the 3x3 calibration matrix, the accelerometer offsets,
  // the final rounding and saturation. The last stage is the output register.
  imusc_matrix u_matrix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s2_valid),
    .in_ready_o  (s2_ready),
    .in_data_i   (s2_data),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_data_o  (out_o.data)
  );

endmodule

// ===== rtl/imusc_check.sv =====
module imusc_check (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  imusc_pkg::out_item_t out_data_i
);
  import imusc_pkg::*;

  logic [2:0] count_q;
  logic [2:0] count_d;

  // Requests inside the block: accepted but not yet delivered.
  always_comb begin
    count_d = count_q + 3'(in_valid_i && in_ready_i) - 3'(out_valid_i && out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !out_valid_i)
    else $error("result shown during reset");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (count_q != 3'd0))
    else $error("result without an outstanding request");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= 3'd4)
    else $error("more requests inside than pipeline stages");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input refused while the output is free");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("stalled result changed or vanished");

endmodule

bind imu_sample_scale_and_calibrate imusc_check u_check (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
